// File: rtl/fbc64_pkg.sv
// Package for the 64-bit Feistel block cipher core: F-table, key byte
// selection and round helper functions. No dependencies.
package fbc64_pkg;

  localparam int RoundCountDefault = 16;
  localparam int RegCipherKey = 0;
  localparam int RegDecryptMode = 1;
  localparam int CfgIndexWidth = 1;

  localparam logic [7:0] FTable [256] = '{
    8'ha3,8'hd7,8'h09,8'h83,8'hf8,8'h48,8'hf6,8'hf4,8'hb3,8'h21,8'h15,8'h78,8'h99,8'hb1,8'haf,8'hf9,
    8'he7,8'h2d,8'h4d,8'h8a,8'hce,8'h4c,8'hca,8'h2e,8'h52,8'h95,8'hd9,8'h1e,8'h4e,8'h38,8'h44,8'h28,
    8'h0a,8'hdf,8'h02,8'ha0,8'h17,8'hf1,8'h60,8'h68,8'h12,8'hb7,8'h7a,8'hc3,8'he9,8'hfa,8'h3d,8'h53,
    8'h96,8'h84,8'h6b,8'hba,8'hf2,8'h63,8'h9a,8'h19,8'h7c,8'hae,8'he5,8'hf5,8'hf7,8'h16,8'h6a,8'ha2,
    8'h39,8'hb6,8'h7b,8'h0f,8'hc1,8'h93,8'h81,8'h1b,8'hee,8'hb4,8'h1a,8'hea,8'hd0,8'h91,8'h2f,8'hb8,
    8'h55,8'hb9,8'hda,8'h85,8'h3f,8'h41,8'hbf,8'he0,8'h5a,8'h58,8'h80,8'h5f,8'h66,8'h0b,8'hd8,8'h90,
    8'h35,8'hd5,8'hc0,8'ha7,8'h33,8'h06,8'h65,8'h69,8'h45,8'h00,8'h94,8'h56,8'h6d,8'h98,8'h9b,8'h76,
    8'h97,8'hfc,8'hb2,8'hc2,8'hb0,8'hfe,8'hdb,8'h20,8'he1,8'heb,8'hd6,8'he4,8'hdd,8'h47,8'h4a,8'h1d,
    8'h42,8'hed,8'h9e,8'h6e,8'h49,8'h3c,8'hcd,8'h43,8'h27,8'hd2,8'h07,8'hd4,8'hde,8'hc7,8'h67,8'h18,
    8'h89,8'hcb,8'h30,8'h1f,8'h8d,8'hc6,8'h8f,8'haa,8'hc8,8'h74,8'hdc,8'hc9,8'h5d,8'h5c,8'h31,8'ha4,
    8'h70,8'h88,8'h61,8'h2c,8'h9f,8'h0d,8'h2b,8'h87,8'h50,8'h82,8'h54,8'h64,8'h26,8'h7d,8'h03,8'h40,
    8'h34,8'h4b,8'h1c,8'h73,8'hd1,8'hc4,8'hfd,8'h3b,8'hcc,8'hfb,8'h7f,8'hab,8'he6,8'h3e,8'h5b,8'ha5,
    8'had,8'h04,8'h23,8'h9c,8'h14,8'h51,8'h22,8'hf0,8'h29,8'h79,8'h71,8'h7e,8'hff,8'h8c,8'h0e,8'he2,
    8'h0c,8'hef,8'hbc,8'h72,8'h75,8'h6f,8'h37,8'ha1,8'hec,8'hd3,8'h8e,8'h62,8'h8b,8'h86,8'h10,8'he8,
    8'h08,8'h77,8'h11,8'hbe,8'h92,8'h4f,8'h24,8'hc5,8'h32,8'h36,8'h9d,8'hcf,8'hf3,8'ha6,8'hbb,8'hac,
    8'h5e,8'h6c,8'ha9,8'h13,8'h57,8'h25,8'hb5,8'he3,8'hbd,8'ha8,8'h3a,8'h01,8'h05,8'h59,8'h2a,8'h46
  };

  // Key byte j of encryption round rnd: rotate left by 12*rnd+j+1, then
  // take byte (4*rnd + j mod 4) mod 8, byte 0 least significant.
  function automatic logic [7:0] key_byte(input logic [63:0] key, input int rnd, input int j);
    logic [63:0] rk;
    int rot;
    int sel;
    rot = (12 * rnd + j + 1) % 64;
    sel = (4 * rnd + (j % 4)) % 8;
    rk = (key << rot) | (key >> (64 - rot));
    return rk[8*sel +: 8];
  endfunction

  function automatic logic [15:0] rol16(input logic [15:0] v);
    return {v[14:0], v[15]};
  endfunction

  function automatic logic [15:0] ror16(input logic [15:0] v);
    return {v[0], v[15:1]};
  endfunction

endpackage

// File: rtl/feistel_block_cipher_64_core.sv
// Top level of the 64-bit Feistel block cipher core: whitening, the round
// pipeline and the configuration registers. Depends on fbc64_pkg, fbc64_round.
//
// Channel   Direction  Handshake                  Payload
// command   in         start & !busy              in_block
// result    out        done strobe, one cycle     out_block
// config    in         cfg_valid & cfg_ready      cfg_index, cfg_data
//
// A new request is taken every cycle; busy is always low. Each request
// passes through one input whitening register, three register stages per
// round (G steps, mix, word update) and one output register.
// The result strobe done is high for exactly one cycle per request.
// Reset (synchronous, active high) clears all valid bits and sets the key
// and mode to zero. The receiver cannot stall, so the pipeline never holds.
module feistel_block_cipher_64_core #(
  parameter int ROUND_COUNT = fbc64_pkg::RoundCountDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_block,
  output logic        done,
  output logic [63:0] out_block,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [fbc64_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] cipher_key;
  logic        decrypt_mode;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers; only bit 0 of the data matters for the mode.
  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= '0;
      decrypt_mode <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == fbc64_pkg::CfgIndexWidth'(fbc64_pkg::RegCipherKey)) begin
        cipher_key <= cfg_data;
      end else if (cfg_index == fbc64_pkg::CfgIndexWidth'(fbc64_pkg::RegDecryptMode)) begin
        decrypt_mode <= cfg_data[0];
      end
    end
  end

  // Chain of round stages; entry 0 is the whitened input.
  logic        stage_valid [ROUND_COUNT+1];
  logic [63:0] stage_words [ROUND_COUNT+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid[0] <= 1'b0;
    end else begin
      stage_valid[0] <= start;
    end
    stage_words[0] <= in_block ^ cipher_key;
  end

  for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
    fbc64_round #(
      .RoundIndex(g),
      .RoundCount(ROUND_COUNT)
    ) u_round (
      .clk         (clk),
      .rst         (rst),
      .cipher_key  (cipher_key),
      .decrypt_mode(decrypt_mode),
      .in_valid    (stage_valid[g]),
      .in_words    (stage_words[g]),
      .out_valid   (stage_valid[g+1]),
      .out_words   (stage_words[g+1])
    );
  end

  // Undo the final swap and whiten again.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage_valid[ROUND_COUNT];
    end
    out_block <= {stage_words[ROUND_COUNT][31:0], stage_words[ROUND_COUNT][63:32]}
                 ^ cipher_key;
  end

endmodule

// File: rtl/fbc64_round.sv
// One cipher round cut into three register stages: first G half, second G
// half with the mix, and the word update. Depends on fbc64_pkg.
module fbc64_round #(
  parameter int RoundIndex = 0,
  parameter int RoundCount = fbc64_pkg::RoundCountDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [63:0] cipher_key,
  input  logic        decrypt_mode,
  input  logic        in_valid,
  input  logic [63:0] in_words,
  output logic        out_valid,
  output logic [63:0] out_words
);

  logic [7:0] ke [12];
  logic [7:0] kd [12];
  logic [7:0] sk [12];

  always_comb begin
    for (int j = 0; j < 12; j++) begin
      ke[j] = fbc64_pkg::key_byte(cipher_key, RoundIndex, j);
      kd[j] = fbc64_pkg::key_byte(cipher_key, RoundCount - 1 - RoundIndex, j);
      sk[j] = decrypt_mode ? kd[j] : ke[j];
    end
  end

  // Stage 1: first two table steps of both G permutations.
  logic        v1;
  logic [63:0] w1;
  logic [7:0]  c0, d0, c1, d1;
  logic [7:0]  c0_next, d0_next, c1_next, d1_next;

  always_comb begin
    c0_next = fbc64_pkg::FTable[in_words[55:48] ^ sk[0]] ^ in_words[63:56];
    d0_next = fbc64_pkg::FTable[c0_next ^ sk[1]] ^ in_words[55:48];
    c1_next = fbc64_pkg::FTable[in_words[39:32] ^ sk[4]] ^ in_words[47:40];
    d1_next = fbc64_pkg::FTable[c1_next ^ sk[5]] ^ in_words[39:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    w1 <= in_words;
    c0 <= c0_next;
    d0 <= d0_next;
    c1 <= c1_next;
    d1 <= d1_next;
  end

  // Stage 2: last two table steps and the mod-65536 mix.
  logic        v2;
  logic [63:0] w2;
  logic [15:0] f0, f1;
  logic [15:0] t0, t1;
  logic [7:0]  e0, e1;

  always_comb begin
    e0 = fbc64_pkg::FTable[d0 ^ sk[2]] ^ c0;
    t0 = {e0, fbc64_pkg::FTable[e0 ^ sk[3]] ^ d0};
    e1 = fbc64_pkg::FTable[d1 ^ sk[6]] ^ c1;
    t1 = {e1, fbc64_pkg::FTable[e1 ^ sk[7]] ^ d1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    w2 <= w1;
    f0 <= t0 + {t1[14:0], 1'b0} + {sk[8], sk[9]};
    f1 <= {t0[14:0], 1'b0} + t1 + {sk[10], sk[11]};
  end

  // Stage 3: mix into words 2 and 3 and swap halves.
  logic [15:0] n0, n1;

  always_comb begin
    if (!decrypt_mode) begin
      n0 = fbc64_pkg::ror16(w2[31:16] ^ f0);
      n1 = fbc64_pkg::rol16(w2[15:0]) ^ f1;
    end else begin
      n0 = fbc64_pkg::rol16(w2[31:16]) ^ f0;
      n1 = fbc64_pkg::ror16(w2[15:0] ^ f1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v2;
    end
    out_words <= {n0, n1, w2[63:32]};
  end

endmodule
